@@ rtl/dbfe_pkg.sv @@
// Shared types and constants for the delimited byte frame extractor.
package dbfe_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 64;

  localparam logic       OP_BYTE    = 1'b0;
  localparam logic       OP_TIMEOUT = 1'b1;

  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd2;
  localparam logic [1:0] KIND_TOO_LONG = 2'd3;

  localparam logic [2:0] REG_USE_STOP   = 3'd0;
  localparam logic [2:0] REG_STOP_VALUE = 3'd1;
  localparam logic [2:0] REG_KEEP_STOP  = 3'd2;
  localparam logic [2:0] REG_DROP_BEGIN = 3'd3;
  localparam logic [2:0] REG_DROP_END   = 3'd4;
  localparam logic [2:0] REG_MAX_LENGTH = 3'd5;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       use_stop;
    logic [7:0] stop_value;
    logic       keep_stop;
    logic [6:0] drop_begin;
    logic [6:0] drop_end;
    logic [5:0] max_length;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage

@@ rtl/dbfe_buffer.sv @@
// Frame buffer: synchronous single-port-write, single-port-read RAM.
module dbfe_buffer #(
  parameter int BUFFER_DEPTH = dbfe_pkg::DEFAULT_BUFFER_DEPTH,
  parameter int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/dbfe_ctrl.sv @@
// Frame controller: length tracking, frame end decisions and buffer drain.
module dbfe_ctrl #(
  parameter int BUFFER_DEPTH = dbfe_pkg::DEFAULT_BUFFER_DEPTH,
  parameter int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dbfe_pkg::cmd_t    cmd,
  input  dbfe_pkg::cfg_t    cfg,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [7:0]        rd_data,
  output logic              result_strobe,
  output dbfe_pkg::result_t result
);
  import dbfe_pkg::*;

  localparam int LW = $clog2(BUFFER_DEPTH + 1);
  localparam int CW = ((LW > 7) ? LW : 7) + 2;

  state_t        state, state_next;
  logic [LW-1:0] len, len_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [AW-1:0] end_ptr, end_ptr_next;
  logic          single, single_next;
  logic [1:0]    kind, kind_next;
  logic          mem_vld, mem_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      len      <= '0;
      single   <= 1'b0;
      mem_vld  <= 1'b0;
    end else begin
      state    <= state_next;
      len      <= len_next;
      single   <= single_next;
      mem_vld  <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    end_ptr  <= end_ptr_next;
    kind     <= kind_next;
    mem_last <= (ptr == end_ptr);
  end

  always_comb begin
    logic [CW-1:0] len_w;
    logic [CW-1:0] elen;
    logic [CW-1:0] nl;
    logic [CW-1:0] limit;
    logic [CW-1:0] cut;
    logic [CW-1:0] last_idx;
    logic          emit;
    state_next   = state;
    len_next     = len;
    ptr_next     = ptr;
    end_ptr_next = end_ptr;
    single_next  = 1'b0;
    kind_next    = kind;
    wr_en        = 1'b0;
    wr_addr      = len[AW-1:0];
    wr_data      = cmd.rx_byte;
    rd_en        = 1'b0;
    rd_addr      = ptr;
    busy         = (state == ST_DRAIN);
    len_w        = CW'(len);
    elen         = len_w;
    nl           = len_w + CW'(1);
    emit         = 1'b0;
    last_idx     = '0;
    limit        = (CW'(cfg.max_length) > CW'(BUFFER_DEPTH - 1)) ?
                   CW'(BUFFER_DEPTH - 1) : CW'(cfg.max_length);
    cut          = CW'(cfg.drop_begin) + CW'(cfg.drop_end);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd.op == OP_TIMEOUT) begin
            if (len != '0) begin
              if (cfg.use_stop) begin
                single_next = 1'b1;
                kind_next   = KIND_TIMEOUT;
                len_next    = '0;
              end else begin
                emit = 1'b1;
              end
            end
          end else if (cfg.use_stop && (cmd.rx_byte == cfg.stop_value)) begin
            if (cfg.keep_stop && (len_w < CW'(BUFFER_DEPTH))) begin
              wr_en = 1'b1;
              elen  = nl;
            end
            emit = 1'b1;
          end else if (len_w < CW'(BUFFER_DEPTH)) begin
            wr_en = 1'b1;
            if (nl > limit) begin
              single_next = 1'b1;
              kind_next   = KIND_TOO_LONG;
              len_next    = '0;
            end else begin
              len_next = nl[LW-1:0];
            end
          end
          if (emit) begin
            len_next = '0;
            if (cut >= elen) begin
              single_next = 1'b1;
              kind_next   = KIND_EMPTY;
            end else begin
              last_idx     = elen - CW'(cfg.drop_end) - CW'(1);
              ptr_next     = AW'(cfg.drop_begin);
              end_ptr_next = last_idx[AW-1:0];
              state_next   = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        rd_en = 1'b1;
        if (ptr == end_ptr) begin
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign result_strobe   = single | mem_vld;
  assign result.kind     = mem_vld ? KIND_BYTE : kind;
  assign result.out_byte = mem_vld ? rd_data : 8'd0;
  assign result.last     = mem_vld ? mem_last : 1'b1;

endmodule

@@ rtl/delimited_byte_frame_extractor_unit.sv @@
// Top level of the delimited byte frame extractor: config registers and core.
//
// Usage:
//   Input: drive cmd and raise start; the transfer happens on a rising edge
//   with start high and busy low. cmd.op selects a received byte or a
//   receive timeout.
//   Output: each result sits on result for one cycle with result_strobe high;
//   the receiver cannot stall, and result.last marks the final result of an
//   input transfer.
//   Config: cfg_we, cfg_index, cfg_data write one register per edge; write
//   only while no frame is being emitted.
// Timing:
//   A stored byte leaves busy low, so bytes are taken back to back. A single
//   result (error or empty frame) appears in the cycle after the transfer.
//   A frame of N output bytes keeps busy high while the buffer RAM is read
//   one entry per cycle; each byte passes through the RAM output register
//   and its valid flag, and bytes follow one per cycle.
// Reset: rst clears the frame length and control state and loads the
//   register defaults; buffer contents are not cleared.
module delimited_byte_frame_extractor_unit #(
  parameter int BUFFER_DEPTH = dbfe_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dbfe_pkg::cmd_t    cmd,
  output logic              result_strobe,
  output dbfe_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import dbfe_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  cfg_t          cfg;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_stop   <= 1'b1;
      cfg.stop_value <= 8'd13;
      cfg.keep_stop  <= 1'b0;
      cfg.drop_begin <= 7'd0;
      cfg.drop_end   <= 7'd0;
      cfg.max_length <= 6'd63;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_USE_STOP:   cfg.use_stop   <= cfg_data[0];
        REG_STOP_VALUE: cfg.stop_value <= cfg_data;
        REG_KEEP_STOP:  cfg.keep_stop  <= cfg_data[0];
        REG_DROP_BEGIN: cfg.drop_begin <= cfg_data[6:0];
        REG_DROP_END:   cfg.drop_end   <= cfg_data[6:0];
        REG_MAX_LENGTH: cfg.max_length <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  dbfe_buffer #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .AW(AW)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dbfe_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .AW(AW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .cfg           (cfg),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule
